// ===== hdl/tosm_pkg.sv =====
//------------------------------------------------------------------------------
// tosm_pkg
// Shared types and constants for the timestamp ordered stream merge unit.
//------------------------------------------------------------------------------
`default_nettype none

package tosm_pkg;

  // Stream count is tied to the 3-bit stream field
  localparam int MAX_STREAMS = 8;

  localparam int STREAM_W = 3;
  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int LEN_W    = 16;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [SEC_W-1:0]    ts_sec;
    logic [USEC_W-1:0]   ts_usec;
    logic [LEN_W-1:0]    cap_len;
    logic                ended;
  } in_item_t;

  typedef struct packed {
    logic [STREAM_W-1:0] winner;
    logic [SEC_W-1:0]    out_sec;
    logic [USEC_W-1:0]   out_usec;
    logic [LEN_W-1:0]    out_len;
    logic                all_done;
  } out_item_t;

  // One pending head as held in the head memory
  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic [LEN_W-1:0]  len;
  } head_t;

endpackage

`default_nettype wire

// ===== hdl/tosm_in_if.sv =====
//------------------------------------------------------------------------------
// tosm_in_if
// Valid/ready channel carrying one stream header or end report per item.
//------------------------------------------------------------------------------
`default_nettype none

interface tosm_in_if;
  logic              valid;
  logic              ready;
  tosm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tosm_out_if.sv =====
//------------------------------------------------------------------------------
// tosm_out_if
// Valid/ready channel carrying one merged header or the done marker per item.
//------------------------------------------------------------------------------
`default_nettype none

interface tosm_out_if;
  logic                valid;
  logic                ready;
  tosm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/timestamp_ordered_stream_merge_unit.sv =====
//------------------------------------------------------------------------------
// timestamp_ordered_stream_merge_unit
// K-way merge of packet header streams by (seconds, microseconds) timestamp.
//------------------------------------------------------------------------------
// Each input item is a header for one stream or an end report. The unit holds
// one pending head per stream in a head memory with one write and one read
// port and, once every active stream holds a head or has ended, emits the
// earliest head (ties go to the higher stream index). When the last active
// stream ends, one item with all_done set is given. To find the head, the
// search reads the n active entries of the head memory one entry per cycle
// through one shared timestamp comparator, n being the active stream count.
// in_ch.ready is low while an item is being processed. A result waiting in
// the output register does not block the next item; a second result holds
// the unit in S_EMIT until the output register is free. active_streams
// (active_r) is to be written through cfg_wr_en / cfg_wr_data only while
// idle; the unit itself does not enforce this.
//------------------------------------------------------------------------------
`default_nettype none

module timestamp_ordered_stream_merge_unit (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_wr_en,
  input  wire [tosm_pkg::CFG_W-1:0]  cfg_wr_data,
  tosm_in_if.sink                    in_ch,
  tosm_out_if.source                 out_ch
);

  localparam int MAX_STREAMS = tosm_pkg::MAX_STREAMS;
  localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W = $clog2(MAX_STREAMS + 1);
  localparam int CMP_W = (CNT_W > tosm_pkg::CFG_W) ? CNT_W : tosm_pkg::CFG_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_APPLY = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tosm_pkg::CFG_W-1:0]   active_r, active_nxt;
  tosm_pkg::in_item_t           item_r;
  logic [MAX_STREAMS-1:0]       present_r, present_nxt;
  logic [MAX_STREAMS-1:0]       closed_r, closed_nxt;
  logic                         newly_r, newly_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]             best_idx_r, best_idx_nxt;
  tosm_pkg::head_t              best_head_r, best_head_nxt;
  logic                         any_r, any_nxt;
  tosm_pkg::out_item_t          res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tosm_pkg::out_item_t          out_data_r, out_data_nxt;

  tosm_pkg::head_t              head_mem [MAX_STREAMS];
  tosm_pkg::head_t              rd_head_r;

  logic [CMP_W-1:0]             n_cmp;
  logic [CMP_W-1:0]             s_ext;
  logic [IDX_W-1:0]             s_idx;
  logic                         s_ok;
  logic                         mem_we;
  tosm_pkg::head_t              wr_head;
  logic [MAX_STREAMS-1:0]       act_mask;
  logic                         all_closed;
  logic                         all_ready;
  logic                         any_head;
  logic                         issue;
  logic                         earlier;
  logic [CMP_W-1:0]             best_ext;

  // Clamp the active count into 1..MAX_STREAMS
  always_comb begin
    if (active_r == '0) begin
      n_cmp = CMP_W'(1);
    end else if (CMP_W'(active_r) > CMP_W'(MAX_STREAMS)) begin
      n_cmp = CMP_W'(MAX_STREAMS);
    end else begin
      n_cmp = CMP_W'(active_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      act_mask[i] = CMP_W'(i) < n_cmp;
    end
  end

  assign s_ext      = CMP_W'(item_r.stream);
  assign s_idx      = s_ext[IDX_W-1:0];
  assign s_ok       = s_ext < n_cmp;
  assign all_closed = &(closed_r | ~act_mask);
  assign all_ready  = &(closed_r | present_r | ~act_mask);
  assign any_head   = |(present_r & ~closed_r & act_mask);
  assign issue      = CMP_W'(cnt_r) < n_cmp;
  assign best_ext   = CMP_W'(best_idx_r);

  assign mem_we       = (state_r == S_APPLY) && s_ok && !item_r.ended && !closed_r[s_idx];
  assign wr_head.sec  = item_r.ts_sec;
  assign wr_head.usec = item_r.ts_usec;
  assign wr_head.len  = item_r.cap_len;

  // Shared comparator: candidate is earlier than or equal to the best so far
  assign earlier = (rd_head_r.sec < best_head_r.sec) ||
                   ((rd_head_r.sec == best_head_r.sec) &&
                    (rd_head_r.usec <= best_head_r.usec));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      head_mem[s_idx] <= wr_head;
    end
    rd_head_r <= head_mem[cnt_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    present_nxt   = present_r;
    closed_nxt    = closed_r;
    newly_nxt     = newly_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    best_idx_nxt  = best_idx_r;
    best_head_nxt = best_head_r;
    any_nxt       = any_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      active_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        newly_nxt = 1'b0;
        if (s_ok && !closed_r[s_idx]) begin
          if (item_r.ended) begin
            closed_nxt[s_idx]  = 1'b1;
            present_nxt[s_idx] = 1'b0;
            newly_nxt          = 1'b1;
          end else begin
            present_nxt[s_idx] = 1'b1;
          end
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        pend_nxt = 1'b0;
        any_nxt = 1'b0;
        if (all_closed) begin
          res_nxt          = '0;
          res_nxt.all_done = 1'b1;
          state_nxt        = newly_r ? S_EMIT : S_IDLE;
        end else if (all_ready && any_head) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle, compare the entry read last cycle
        pend_nxt     = issue;
        pend_idx_nxt = cnt_r[IDX_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (pend_r && present_r[pend_idx_r] && (!any_r || earlier)) begin
          best_idx_nxt  = pend_idx_r;
          best_head_nxt = rd_head_r;
          any_nxt       = 1'b1;
        end
        if (!issue && !pend_r) begin
          res_nxt.winner          = best_ext[tosm_pkg::STREAM_W-1:0];
          res_nxt.out_sec         = best_head_r.sec;
          res_nxt.out_usec        = best_head_r.usec;
          res_nxt.out_len         = best_head_r.len;
          res_nxt.all_done        = 1'b0;
          present_nxt[best_idx_r] = 1'b0;
          state_nxt               = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= tosm_pkg::ACTIVE_RESET;
      present_r   <= '0;
      closed_r    <= '0;
      newly_r     <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      present_r   <= present_nxt;
      closed_r    <= closed_nxt;
      newly_r     <= newly_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.data;
    end
    pend_idx_r  <= pend_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_head_r <= best_head_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire
